// File: hdl/sprite_animation_sequencer_top_assert.svh
`ifndef SPRITE_ANIMATION_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked while the block is out of reset.
`define SAS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while the block is out of reset.
`define SAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sas_pkg.sv
`default_nettype none

package sas_pkg;

	localparam int NUM_STATES       = 16;
	localparam int FRAMES_PER_STATE = 16;
	localparam int TIME_WIDTH       = 24;

	localparam int OP_W      = 2;
	localparam int STATE_W   = 4;
	localparam int SLOT_W    = 4;
	localparam int FRAME_W   = 16;
	localparam int CNT_W     = 5;
	localparam int TICKS_W   = 16;
	localparam int ELAPSED_W = TIME_WIDTH + 1;
	localparam int PROD_W    = ELAPSED_W + CNT_W;
	localparam int STEP_W    = $clog2(PROD_W);

	localparam int FRAME_DEPTH  = NUM_STATES * FRAMES_PER_STATE;
	localparam int FRAME_ADDR_W = STATE_W + SLOT_W;

	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
	localparam logic [OP_W-1:0] OP_BIND    = 2'd2;
	localparam logic [OP_W-1:0] OP_GOTO    = 2'd3;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] dur;
		logic [CNT_W-1:0]      cnt;
		logic                  looping;
		logic                  auto_next;
		logic [STATE_W-1:0]    nxt;
	} state_entry_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic hop;
		logic mul;
		logic step;
		logic idx;
	} sas_cmd_t;

	typedef struct packed {
		logic bound_any;
		logic hop_ok;
		logic div_last;
	} sas_sts_t;

endpackage

`default_nettype wire

// File: hdl/sas_ram.sv
`default_nettype none

module sas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hdl/sas_ctrl.sv
`default_nettype none

module sas_ctrl import sas_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire sas_sts_t sts,
	output sas_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_HOP  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_IDX  = 4'd6;
	localparam logic [3:0] S_FRD  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       hopped_q, hopped_d;

	always_comb begin
		state_d  = state_q;
		hopped_d = hopped_q;
		cmd      = '0;
		done     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					hopped_d  = 1'b0;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				state_d = sts.bound_any ? S_HOP : S_OUT;
			end
			S_HOP: begin
				if (!hopped_q && sts.hop_ok) begin
					cmd.hop  = 1'b1;
					hopped_d = 1'b1;
					state_d  = S_RD;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = S_IDX;
				end
			end
			S_IDX: begin
				cmd.idx = 1'b1;
				state_d = S_FRD;
			end
			S_FRD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hopped_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			hopped_q <= hopped_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/sas_dp.sv
`default_nettype none

module sas_dp import sas_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sas_cmd_t              cmd,
	output sas_sts_t                   sts,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic [STATE_W-1:0]    state_id,
	input  wire logic [SLOT_W-1:0]     frame_slot,
	input  wire logic [FRAME_W-1:0]    frame_value,
	input  wire logic [TIME_WIDTH-1:0] anim_duration,
	input  wire logic [CNT_W-1:0]      frame_count,
	input  wire logic                  loops,
	input  wire logic                  has_fallback,
	input  wire logic [STATE_W-1:0]    fallback_state,
	input  wire logic                  restart,
	input  wire logic [TICKS_W-1:0]    ticks,
	output logic      [STATE_W-1:0]    current_state,
	output logic      [FRAME_W-1:0]    shown_frame,
	output logic                       finished,
	output logic                       any_bound
);

	localparam int SUM_W   = ELAPSED_W + 1;
	localparam int ENTRY_W = $bits(state_entry_t);

	logic [OP_W-1:0]       op_q;
	logic [STATE_W-1:0]    sid_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [FRAME_W-1:0]    fval_q;
	logic [TIME_WIDTH-1:0] dur_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  loops_q;
	logic                  hasfb_q;
	logic [STATE_W-1:0]    fb_q;
	logic                  again_q;
	logic [TICKS_W-1:0]    ticks_q;

	logic [NUM_STATES-1:0] bound_q;
	logic                  bound_any_q;
	logic [STATE_W-1:0]    active_q;
	logic [ELAPSED_W-1:0]  elapsed_q;

	logic [TIME_WIDTH-1:0] d_q;
	logic [CNT_W-1:0]      c_q;
	logic                  loop_q;
	logic                  fin_q;
	logic [PROD_W-1:0]     quot_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]      r_q;
	logic [STEP_W-1:0]     step_q;
	logic [SLOT_W-1:0]     idx_q;

	logic [ENTRY_W-1:0]    st_rdata;
	state_entry_t          ent;
	state_entry_t          new_ent;
	logic [FRAME_W-1:0]    fr_rdata;

	logic [TIME_WIDTH-1:0] d_eff;
	logic [CNT_W-1:0]      c_eff;
	logic                  reached;
	logic [SUM_W-1:0]      adv_sum;
	logic                  go_ok;
	logic [TIME_WIDTH:0]   trial;
	logic                  qbit;
	logic [CNT_W:0]        r_trial;
	logic [PROD_W-1:0]     product;

	assign ent = st_rdata;

	assign new_ent.dur       = dur_q;
	assign new_ent.cnt       = cnt_q;
	assign new_ent.looping   = loops_q;
	assign new_ent.auto_next = hasfb_q && (fb_q != sid_q);
	assign new_ent.nxt       = fb_q;

	sas_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_STATES)
	) u_state_ram (
		.clk  (clk),
		.we   (cmd.exec && (op_q == OP_BIND)),
		.waddr(sid_q),
		.wdata(new_ent),
		.raddr(active_q),
		.rdata(st_rdata)
	);

	sas_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(FRAME_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (cmd.exec && (op_q == OP_WRITE)),
		.waddr({sid_q, slot_q}),
		.wdata(fval_q),
		.raddr({active_q, idx_q}),
		.rdata(fr_rdata)
	);

	always_comb begin
		d_eff = (ent.dur == '0) ? TIME_WIDTH'(1) : ent.dur;
		if (ent.cnt == '0) begin
			c_eff = CNT_W'(1);
		end else if (ent.cnt > CNT_W'(FRAMES_PER_STATE)) begin
			c_eff = CNT_W'(FRAMES_PER_STATE);
		end else begin
			c_eff = ent.cnt;
		end
	end

	assign reached = (elapsed_q >= {1'b0, d_eff});
	assign adv_sum = {1'b0, elapsed_q} + SUM_W'(ticks_q);
	assign go_ok   = !((sid_q == active_q) && !again_q) && bound_q[sid_q];
	assign product = {{CNT_W{1'b0}}, elapsed_q} * {{ELAPSED_W{1'b0}}, c_eff};

	assign trial   = {rem_q, quot_q[PROD_W-1]};
	assign qbit    = (trial >= {1'b0, d_q});
	assign r_trial = {r_q, qbit};

	assign sts.bound_any = bound_any_q;
	assign sts.hop_ok    = ent.auto_next && reached && bound_q[ent.nxt];
	assign sts.div_last  = (step_q == STEP_W'(PROD_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= operation;
			sid_q   <= state_id;
			slot_q  <= frame_slot;
			fval_q  <= frame_value;
			dur_q   <= anim_duration;
			cnt_q   <= frame_count;
			loops_q <= loops;
			hasfb_q <= has_fallback;
			fb_q    <= fallback_state;
			again_q <= restart;
			ticks_q <= ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q     <= '0;
			bound_any_q <= 1'b0;
			active_q    <= '0;
			elapsed_q   <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_ADVANCE: begin
					elapsed_q <= adv_sum[ELAPSED_W] ? '1 : adv_sum[ELAPSED_W-1:0];
				end
				OP_BIND: begin
					bound_q[sid_q] <= 1'b1;
					bound_any_q    <= 1'b1;
					if (!bound_any_q || (active_q == sid_q)) begin
						active_q  <= sid_q;
						elapsed_q <= '0;
					end
				end
				OP_GOTO: begin
					if (go_ok) begin
						active_q  <= sid_q;
						elapsed_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.hop) begin
			elapsed_q <= elapsed_q - {1'b0, d_eff};
			active_q  <= ent.nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			d_q    <= d_eff;
			c_q    <= c_eff;
			loop_q <= ent.looping;
			fin_q  <= reached;
			quot_q <= product;
			rem_q  <= '0;
			r_q    <= '0;
			step_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= qbit ? TIME_WIDTH'(trial - {1'b0, d_q}) : trial[TIME_WIDTH-1:0];
			quot_q <= {quot_q[PROD_W-2:0], qbit};
			r_q    <= (r_trial >= {1'b0, c_q}) ? CNT_W'(r_trial - {1'b0, c_q})
				: r_trial[CNT_W-1:0];
			step_q <= step_q + 1'b1;
		end
		if (cmd.idx) begin
			if (loop_q) begin
				idx_q <= r_q[SLOT_W-1:0];
			end else if (quot_q >= PROD_W'(c_q)) begin
				idx_q <= SLOT_W'(c_q - 1'b1);
			end else begin
				idx_q <= quot_q[SLOT_W-1:0];
			end
		end
	end

	assign current_state = bound_any_q ? active_q : '0;
	assign shown_frame   = bound_any_q ? fr_rdata : '0;
	assign finished      = bound_any_q & fin_q;
	assign any_bound     = bound_any_q;

endmodule

`default_nettype wire

// File: hdl/sprite_animation_sequencer_top.sv
// Channel   Handshake                  Payload
// request   start, busy (start & !busy) operation .. ticks
// result    done (one-cycle strobe)     current_state, shown_frame, finished, any_bound
//
// A request steps through execute, state read, multiply, 30-step serial divide, index
// and frame read to done; a fallback hop adds a hop and a second state read. With no
// state bound, it goes from state read to done, since no frame index is formed.
// busy stays high from the cycle after acceptance through the done cycle.
// Reset clears the bound flags, the current state and the elapsed time; tables are
// undefined until written. The result cannot be stalled.
`default_nettype none

module sprite_animation_sequencer_top import sas_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic [STATE_W-1:0]    state_id,
	input  wire logic [SLOT_W-1:0]     frame_slot,
	input  wire logic [FRAME_W-1:0]    frame_value,
	input  wire logic [TIME_WIDTH-1:0] anim_duration,
	input  wire logic [CNT_W-1:0]      frame_count,
	input  wire logic                  loops,
	input  wire logic                  has_fallback,
	input  wire logic [STATE_W-1:0]    fallback_state,
	input  wire logic                  restart,
	input  wire logic [TICKS_W-1:0]    ticks,
	output logic                       done,
	output logic      [STATE_W-1:0]    current_state,
	output logic      [FRAME_W-1:0]    shown_frame,
	output logic                       finished,
	output logic                       any_bound
);

	`include "sprite_animation_sequencer_top_assert.svh"

	sas_cmd_t cmd;
	sas_sts_t sts;

	sas_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	sas_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.state_id      (state_id),
		.frame_slot    (frame_slot),
		.frame_value   (frame_value),
		.anim_duration (anim_duration),
		.frame_count   (frame_count),
		.loops         (loops),
		.has_fallback  (has_fallback),
		.fallback_state(fallback_state),
		.restart       (restart),
		.ticks         (ticks),
		.current_state (current_state),
		.shown_frame   (shown_frame),
		.finished      (finished),
		.any_bound     (any_bound)
	);

	`SAS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !done, "accepted request did not start")
	`SAS_ASSERT_NEXT(a_idle_after_done, done, !busy, "controller did not return to idle after done")
	`SAS_ASSERT_NEXT(a_bound_sticky, sts.bound_any, sts.bound_any, "bound flag was lost")
	`SAS_ASSERT_IMPL(a_no_cmd_when_idle, !busy, !(cmd.exec || cmd.hop || cmd.mul || cmd.step), "datapath command while idle")

endmodule

`default_nettype wire
